// ===== rtl/chained_interval_remap_min_unit_defines.svh =====
// Assertion helpers shared by the RTL files.
`ifndef CHAINED_INTERVAL_REMAP_MIN_UNIT_DEFINES_SVH
`define CHAINED_INTERVAL_REMAP_MIN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CIRM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CIRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cirm_pkg.sv =====
package cirm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  localparam logic [31:0] MIN_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] src;
    logic [31:0] len;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic start;
    logic load;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/chained_interval_remap_min_unit.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | req_type map_select dest_start src_start
//         |           |                      | range_length seed_value
// out     | output    | out_valid / out_stall| location lowest_location status
//
// Load, clear and unused requests write the output register in the cycle they are accepted.
// A query walks the cells in order; each cell reads one entry per cycle from its
// RAM and stops at the first entry that holds the value or at its last entry.
// Synchronous reset empties every table and sets the minimum to all ones.
// in_stall is high during a query and while an unaccepted result waits.
`include "chained_interval_remap_min_unit_defines.svh"

module chained_interval_remap_min_unit #(
  parameter int ENTRIES_PER_MAP = 64,
  parameter int NUM_MAPS        = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  map_select,
  input  logic [31:0] dest_start,
  input  logic [31:0] src_start,
  input  logic [31:0] range_length,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] location,
  output logic [31:0] lowest_location,
  output logic        status
);
  import cirm_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state;
  logic [31:0]         min_loc;
  logic                accept;
  logic                is_load;
  logic                is_query;
  logic                is_clear;
  logic [NUM_MAPS-1:0] sel_hit;
  logic [NUM_MAPS-1:0] full_vec;
  logic [NUM_MAPS-1:0] done_vec;
  logic                load_ok;
  logic [31:0]         vals [NUM_MAPS];
  cell_ctl_t           ctl [NUM_MAPS];
  entry_t              load_entry;
  logic [31:0]         final_loc;
  logic                res_load;

  assign in_stall   = (state == S_RUN) || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign is_load    = (req_type == REQ_LOAD);
  assign is_query   = (req_type == REQ_QUERY);
  assign is_clear   = (req_type == REQ_CLEAR);
  assign load_entry = '{dst: dest_start, src: src_start, len: range_length};
  assign load_ok    = |(sel_hit & ~full_vec);
  assign final_loc  = vals[NUM_MAPS-1];
  // output register takes a new result this cycle
  assign res_load   = (state == S_IDLE) ? (accept && !is_query) : done_vec[NUM_MAPS-1];

  for (genvar i = 0; i < NUM_MAPS; i++) begin : g_cell
    logic [31:0] chain_in;

    assign sel_hit[i]   = ({29'd0, map_select} == 32'(i));
    assign ctl[i].load  = accept && is_load && sel_hit[i];
    assign ctl[i].clear = accept && is_clear;
    if (i == 0) begin : g_head
      assign ctl[i].start = accept && is_query;
      assign chain_in     = seed_value;
    end else begin : g_link
      assign ctl[i].start = done_vec[i-1];
      assign chain_in     = vals[i-1];
    end

    cirm_cell #(
      .ENTRIES (ENTRIES_PER_MAP)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[i]),
      .value_in   (chain_in),
      .load_entry (load_entry),
      .full       (full_vec[i]),
      .done       (done_vec[i]),
      .value_out  (vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      min_loc   <= MIN_RESET;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              REQ_LOAD: begin
                location        <= '0;
                status          <= !load_ok;
                lowest_location <= min_loc;
              end
              REQ_QUERY: begin
                state <= S_RUN;
              end
              REQ_CLEAR: begin
                location        <= '0;
                status          <= 1'b0;
                min_loc         <= MIN_RESET;
                lowest_location <= MIN_RESET;
              end
              default: begin
                location        <= '0;
                status          <= 1'b0;
                lowest_location <= min_loc;
              end
            endcase
          end
        end
        S_RUN: begin
          if (done_vec[NUM_MAPS-1]) begin
            location  <= final_loc;
            status    <= 1'b0;
            if (final_loc < min_loc) begin
              min_loc         <= final_loc;
              lowest_location <= final_loc;
            end else begin
              lowest_location <= min_loc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CIRM_ASSERT(a_run_no_out, state == S_RUN, !out_valid, "result pending during a query")
  `CIRM_ASSERT(a_done_in_run, done_vec[NUM_MAPS-1], state == S_RUN, "chain done outside a query")
  `CIRM_ASSERT_NEXT(a_query_runs, accept && is_query, state == S_RUN, "query did not start")
endmodule

// ===== rtl/cirm_ram.sv =====
module cirm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cirm_cell.sv =====
`include "chained_interval_remap_min_unit_defines.svh"

module cirm_cell #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cirm_pkg::cell_ctl_t ctl,
  input  logic [31:0]        value_in,
  input  cirm_pkg::entry_t   load_entry,
  output logic               full,
  output logic               done,
  output logic [31:0]        value_out
);
  import cirm_pkg::*;

  localparam int AW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic {C_IDLE, C_SCAN} cstate_t;

  cstate_t       state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_idx;
  logic [31:0]   val;
  entry_t        rd_entry;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [32:0]   src_end;
  logic          hit;
  logic          last;

  assign full    = (cnt == CW'(ENTRIES));
  assign wr_en   = ctl.load && !full;
  // start reads entry 0; while scanning, rd_idx is the next entry to fetch
  assign rd_addr = (state == C_SCAN) ? rd_idx[AW-1:0] : '0;

  cirm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt[AW-1:0]),
    .wdata (load_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // interval end at 33 bits so it never wraps
  assign src_end = {1'b0, rd_entry.src} + {1'b0, rd_entry.len};
  assign hit     = (val >= rd_entry.src) && ({1'b0, val} < src_end);
  // rd_entry holds entry rd_idx-1, so this is the last loaded entry
  assign last    = (rd_idx == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        cnt <= '0;
      end else if (wr_en) begin
        cnt <= cnt + 1'b1;
      end
      unique case (state)
        C_IDLE: begin
          done <= ctl.start && (cnt == '0);
          if (ctl.start) begin
            val    <= value_in;
            rd_idx <= CW'(1);
            if (cnt == '0) begin
              value_out <= value_in;
            end else begin
              state <= C_SCAN;
            end
          end
        end
        C_SCAN: begin
          if (hit) begin
            done      <= 1'b1;
            value_out <= val + (rd_entry.dst - rd_entry.src);
            state     <= C_IDLE;
          end else if (last) begin
            done      <= 1'b1;
            value_out <= val;
            state     <= C_IDLE;
          end else begin
            done   <= 1'b0;
            rd_idx <= rd_idx + 1'b1;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= C_IDLE;
        end
      endcase
    end
  end

  `CIRM_ASSERT(a_cnt_bound, 1'b1, cnt <= CW'(ENTRIES), "entry count above table depth")
  `CIRM_ASSERT(a_start_idle, ctl.start, state == C_IDLE, "cell started while scanning")
  `CIRM_ASSERT(a_done_idle, done, state == C_IDLE, "cell done but still scanning")
endmodule
